>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> sv/dopq_pkg.sv
// Shared types and constants for the drop-oldest packet queue.
package dopq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;

    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'h0FF;

    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int TAG_W      = 32;
    localparam int LEN_W      = 16;
    localparam int ENTRY_W    = TAG_W + LEN_W;
    localparam int SMALL_W    = 9;
    localparam int PKT_CNT_W  = 32;
    localparam int BYTE_CNT_W = 48;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = STATUS_W + TAG_W + LEN_W + 3 * SMALL_W
                                 + 3 * PKT_CNT_W + BYTE_CNT_W - STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_PEEK    = 2'd2,
        FUNC_CANCEL  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_CANCELLED = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;  // latch the incoming request
        logic commit;   // update queue state and load the result register
    } t_cmd;

endpackage

>>> sv/drop_oldest_packet_queue.sv
// Top level of the drop-oldest packet descriptor queue with statistics.
// Each request on the slave stream is one operation, selected by tuser:
// enqueue, dequeue, peek or cancel. An enqueue carries a 32-bit tag and a
// 16-bit length; if occupancy is at or above the queue limit, the oldest
// entries are discarded first (all in the same request) and counted as
// overflow. Dequeue pops the head, peek reads it in place; both answer
// "empty" on an empty queue. After a cancel, every dequeue answers
// "cancelled" until reset. Every request yields exactly one result, which
// carries the status in tuser and, in tdata, the head descriptor, the
// number dropped by this request, the occupancy after it and the running
// statistics (all wrapping). A request is first latched while the head
// entry is read from the registered-output descriptor RAM; then pointers
// and counters are updated and the result register is loaded.
// A new request is taken while the previous result still waits on the
// master side; a held result stalls only the update step of the next.
// The limit register (reset 255) is clamped to 1..QUEUE_DEPTH and must be
// written only while no request is in flight. The RAM is not cleared at
// reset; entries are only read while held, so no clearing pass is needed.
module drop_oldest_packet_queue
    import dopq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: queue limit
    input  logic                   i_cfg_we,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // entry_tag[31:0], entry_length[47:32]
    input  logic [FUNC_W-1:0]      i_s_tuser,   // func[1:0]
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // head_tag[31:0], head_length[47:32], dropped_now[56:48], occupancy[65:57],
    // packets_enqueued[97:66], bytes_enqueued[145:98], packets_dequeued[177:146],
    // packets_overflowed[209:178], high_water[218:210], zero pad above
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]    o_m_tuser    // status[1:0]
);

    t_cmd cmd;

    // handshake sequencing
    dopq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // queue storage, drop logic and statistics
    dopq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

>>> sv/dopq_ctrl.sv
// Request/result handshake controller for the drop-oldest packet queue.
module dopq_ctrl
    import dopq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_s_tready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result slot free, or being drained this cycle
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> sv/dopq_datapath.sv
// Descriptor store, pointers, statistics counters and result register.
module dopq_datapath
    import dopq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cfg_we,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [FUNC_W-1:0]      i_s_tuser,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]    o_m_tuser
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SW    = EW + 1;

    // descriptor store: {length, tag}
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [PTR_W-1:0]      r_rp, n_rp, r_wp, n_wp;
    logic [CNT_W-1:0]      r_count, n_count, r_hw, n_hw;
    logic                  r_cancelled, n_cancelled;
    logic [PKT_CNT_W-1:0]  r_enq_cnt, n_enq_cnt, r_deq_cnt, n_deq_cnt;
    logic [PKT_CNT_W-1:0]  r_ovf_cnt, n_ovf_cnt;
    logic [BYTE_CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [LIMIT_W-1:0]    r_limit;

    // latched request
    t_func             r_func;
    logic [TAG_W-1:0]  r_tag;
    logic [LEN_W-1:0]  r_len;

    // result register
    t_status           r_status, n_status;
    logic [TAG_W-1:0]  r_head_tag, n_head_tag;
    logic [LEN_W-1:0]  r_head_len, n_head_len;
    logic [EW-1:0]     r_dropped, n_dropped;

    logic              mem_we;

    // drop arithmetic
    logic [EW-1:0]     lim_eff, cnt_e, drop_cnt;
    logic [SW-1:0]     rp_sum;
    logic [PTR_W-1:0]  rp_after_drop, rp_inc, wp_inc;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= {r_len, r_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_s_tuser);
            r_tag  <= i_s_tdata[TAG_W-1:0];
            r_len  <= i_s_tdata[TAG_W +: LEN_W];
        end
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_head_tag <= n_head_tag;
            r_head_len <= n_head_len;
            r_dropped  <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_hw        <= '0;
            r_cancelled <= 1'b0;
            r_enq_cnt   <= '0;
            r_deq_cnt   <= '0;
            r_ovf_cnt   <= '0;
            r_byte_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_rp        <= n_rp;
                r_wp        <= n_wp;
                r_count     <= n_count;
                r_hw        <= n_hw;
                r_cancelled <= n_cancelled;
                r_enq_cnt   <= n_enq_cnt;
                r_deq_cnt   <= n_deq_cnt;
                r_ovf_cnt   <= n_ovf_cnt;
                r_byte_cnt  <= n_byte_cnt;
            end
        end
    end

    // limit clamped to 1..QUEUE_DEPTH; drop enough to leave room for one
    always_comb begin
        if (r_limit == '0) begin
            lim_eff = EW'(1);
        end else if (EW'(r_limit) > EW'(QUEUE_DEPTH)) begin
            lim_eff = EW'(QUEUE_DEPTH);
        end else begin
            lim_eff = EW'(r_limit);
        end
        cnt_e    = EW'(r_count);
        drop_cnt = (cnt_e >= lim_eff) ? (cnt_e - lim_eff + EW'(1)) : '0;
        rp_sum   = SW'(r_rp) + SW'(drop_cnt);
        if (rp_sum >= SW'(QUEUE_DEPTH)) begin
            rp_sum = rp_sum - SW'(QUEUE_DEPTH);
        end
        rp_after_drop = rp_sum[PTR_W-1:0];
        rp_inc = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        wp_inc = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    end

    always_comb begin
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_count     = r_count;
        n_hw        = r_hw;
        n_cancelled = r_cancelled;
        n_enq_cnt   = r_enq_cnt;
        n_deq_cnt   = r_deq_cnt;
        n_ovf_cnt   = r_ovf_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_status    = STATUS_OK;
        n_head_tag  = '0;
        n_head_len  = '0;
        n_dropped   = '0;
        mem_we      = 1'b0;
        case (r_func)
            FUNC_ENQUEUE: begin
                mem_we     = i_cmd.commit;
                n_rp       = rp_after_drop;
                n_wp       = wp_inc;
                n_count    = CNT_W'(cnt_e - drop_cnt + EW'(1));
                n_dropped  = drop_cnt;
                n_enq_cnt  = r_enq_cnt + PKT_CNT_W'(1);
                n_ovf_cnt  = r_ovf_cnt + PKT_CNT_W'(drop_cnt);
                n_byte_cnt = r_byte_cnt + BYTE_CNT_W'(r_len);
                if (n_count > r_hw) begin
                    n_hw = n_count;
                end
            end
            FUNC_DEQUEUE, FUNC_PEEK: begin
                if (r_func == FUNC_DEQUEUE && r_cancelled) begin
                    n_status = STATUS_CANCELLED;
                end else if (r_count == '0) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_head_tag = r_rd_data[TAG_W-1:0];
                    n_head_len = r_rd_data[TAG_W +: LEN_W];
                    if (r_func == FUNC_DEQUEUE) begin
                        n_rp      = rp_inc;
                        n_count   = r_count - CNT_W'(1);
                        n_deq_cnt = r_deq_cnt + PKT_CNT_W'(1);
                    end
                end
            end
            FUNC_CANCEL: begin
                n_cancelled = 1'b1;
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    // counters are live: they only move on commit, which also loads the result
    assign o_m_tuser = r_status;
    assign o_m_tdata = {
        {OUT_PAD_W{1'b0}},
        SMALL_W'(r_hw),
        r_ovf_cnt,
        r_deq_cnt,
        r_byte_cnt,
        r_enq_cnt,
        SMALL_W'(r_count),
        SMALL_W'(r_dropped),
        r_head_len,
        r_head_tag
    };

endmodule

>>> sv/dopq_checker.sv
// Port-level checks for the drop-oldest packet queue, bound to the top level.
`include "assert_macros.svh"

module dopq_checker
    import dopq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [STATUS_W-1:0]    o_m_tuser
);

    // a stalled result holds
    `ASSERT_CLK(a_result_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // nothing is offered right after reset
    `ASSERT_CLK_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)

    // a taken request blocks the next one in the cycle after it is taken
    `ASSERT_CLK(a_req_gap, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready)

    // a failed dequeue or peek carries no descriptor and drops nothing
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != STATUS_OK |-> o_m_tdata[56:0] == 57'd0)

    // high-water mark never below current occupancy
    `ASSERT_CLK(a_hw_bound, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[218:210] >= o_m_tdata[65:57])

endmodule

bind drop_oldest_packet_queue dopq_checker u_dopq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
